// File: hdl/bse_pkg.sv
// Bitmap set engine: shared widths and command codes.
// No dependencies; imported everywhere except bse_ram.
package bse_pkg;

   localparam int WORD_W  = 64;
   localparam int CMD_W   = 4;
   localparam int ELEM_W  = 8;
   localparam int COUNT_W = 9;
   localparam int BIT_W   = 6;
   localparam int POP_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR     = 4'd0,
      CMD_INSERT    = 4'd1,
      CMD_REMOVE    = 4'd2,
      CMD_TEST      = 4'd3,
      CMD_MIN       = 4'd4,
      CMD_MAX       = 4'd5,
      CMD_UNION     = 4'd6,
      CMD_INTERSECT = 4'd7,
      CMD_DIFF      = 4'd8,
      CMD_COPY      = 4'd9,
      CMD_EQUAL     = 4'd10,
      CMD_COUNT     = 4'd11
   } cmd_type;

endpackage

// File: hdl/bse_if.sv
// Bitmap set engine: valid/ready channel interfaces for commands and results.
// Depends on bse_pkg.
interface bse_req_if import bse_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic              set_select;
   logic [ELEM_W-1:0] element;

   modport source (output valid, cmd, set_select, element, input ready);
   modport sink   (input valid, cmd, set_select, element, output ready);
endinterface

interface bse_rsp_if import bse_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [ELEM_W-1:0]  element_out;
   logic [COUNT_W-1:0] member_count;
   logic               is_empty;

   modport source (output valid, found, element_out, member_count, is_empty, input ready);
   modport sink   (input valid, found, element_out, member_count, is_empty, output ready);
endinterface

// File: hdl/bitmap_set_engine_core.sv
// Bitmap set engine top level: command sequencer around two bitmap RAMs.
// Depends on bse_pkg, bse_if, bse_ram and bse_popcnt.
//
// Usage:
//   req_chan carries one command (cmd, set_select, element) per transfer;
//   rsp_chan returns exactly one result per command, in order.
//   Each set lives in its own RAM of (SET_SIZE+63)/64 words of 64 bits.
//   One command is worked at a time. Clear, count and unused codes go
//   straight to the result; insert, remove and test read the element's
//   word, and insert and remove write it back; min, max, union, intersect,
//   difference, copy and equal walk over the words at one RAM read per
//   cycle, and union, intersect and difference drain the popcount pipeline.
//   A new command can be taken in the cycle after the result is registered.
//   The result register holds while rsp_chan.ready is low; the sequencer
//   still takes one more command, then waits with its finished result and
//   takes no new command. Reset empties both sets at once through per-word
//   valid bits and zeroes the member counts; no clearing pass is needed.
module bitmap_set_engine_core import bse_pkg::*; #(
   parameter int SET_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   bse_req_if.sink     req_chan,
   bse_rsp_if.source   rsp_chan
);

   localparam int WORDS = (SET_SIZE + WORD_W - 1) / WORD_W;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W = $clog2(WORDS + 1);
   localparam int CMP_W = 13;

   typedef enum logic [2:0] {ST_IDLE, ST_ELEM, ST_WALK, ST_ENC, ST_FIN} state_type;

   function automatic logic [BIT_W-1:0] low_one(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (w[i]) pos = BIT_W'(i);
      end
      return pos;
   endfunction

   function automatic logic [BIT_W-1:0] high_one(input logic [WORD_W-1:0] w);
      logic [BIT_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (w[i]) pos = BIT_W'(i);
      end
      return pos;
   endfunction

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic               sel_ff, sel_in;
   logic [ELEM_W-1:0]  elem_ff, elem_in;
   logic               range_ff, range_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               pend_ff, pend_in;
   logic [WAW-1:0]     pidx_ff, pidx_in;
   logic               pvld0_ff, pvld0_in, pvld1_ff, pvld1_in;
   logic [WORDS-1:0]   valid0_ff, valid0_in, valid1_ff, valid1_in;
   logic [COUNT_W-1:0] count_ff [2];
   logic [COUNT_W-1:0] count_in [2];
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               hit_ff, hit_in;
   logic [WORD_W-1:0]  edge_word_ff, edge_word_in;
   logic [WAW-1:0]     edge_idx_ff, edge_idx_in;
   logic               eq_ff, eq_in;
   logic               found_ff, found_in;
   logic [ELEM_W-1:0]  eout_ff, eout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [ELEM_W-1:0]  rsp_elem_ff, rsp_elem_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               rd_en;
   logic [WAW-1:0]     rd_addr;
   logic               wr_en;
   logic [WAW-1:0]     wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [WORD_W-1:0]  q0, q1, d0, d1, dsel;
   logic               pc_valid, pc_out_valid, pc_busy;
   logic [POP_W-1:0]   pc_count;
   logic               accept;
   logic [WAW-1:0]     req_word;
   logic [WORD_W-1:0]  bit_mask;
   logic               member;
   logic [WAW-1:0]     walk_addr;
   logic               walk_done;

   assign accept   = req_chan.valid & req_chan.ready;
   assign req_word = WAW'(req_chan.element >> BIT_W);
   assign d0       = pvld0_ff ? q0 : '0;
   assign d1       = pvld1_ff ? q1 : '0;
   assign dsel     = sel_ff ? d1 : d0;
   assign bit_mask = WORD_W'(1) << elem_ff[BIT_W-1:0];
   assign member   = range_ff & (|(dsel & bit_mask));
   assign walk_addr = (cmd_ff == CMD_MAX) ? (WAW'(WORDS - 1) - issue_ff[WAW-1:0])
                                          : issue_ff[WAW-1:0];
   assign walk_done = (issue_ff == CNT_W'(WORDS)) & ~pend_ff & ~pc_busy;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      sel_in       = sel_ff;
      elem_in      = elem_ff;
      range_in     = range_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pidx_in      = pidx_ff;
      pvld0_in     = pvld0_ff;
      pvld1_in     = pvld1_ff;
      valid0_in    = valid0_ff;
      valid1_in    = valid1_ff;
      count_in     = count_ff;
      acc_in       = acc_ff;
      hit_in       = hit_ff;
      edge_word_in = edge_word_ff;
      edge_idx_in  = edge_idx_ff;
      eq_in        = eq_ff;
      found_in     = found_ff;
      eout_in      = eout_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_count_in = rsp_count_ff;
      rsp_empty_in = rsp_empty_ff;
      rd_en        = 1'b0;
      rd_addr      = walk_addr;
      wr_en        = 1'b0;
      wr_addr      = pidx_ff;
      wr_data      = '0;
      pc_valid     = 1'b0;

      if (pc_out_valid) begin
         acc_in = acc_ff + COUNT_W'(pc_count);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_chan.cmd);
               sel_in   = req_chan.set_select;
               elem_in  = req_chan.element;
               range_in = CMP_W'(req_chan.element) < CMP_W'(SET_SIZE);
               issue_in = '0;
               acc_in   = '0;
               hit_in   = 1'b0;
               eq_in    = 1'b1;
               found_in = 1'b0;
               eout_in  = '0;
               rd_en    = 1'b1;
               rd_addr  = req_word;
               pvld0_in = valid0_ff[req_word];
               pvld1_in = valid1_ff[req_word];
               case (cmd_type'(req_chan.cmd))
                  CMD_CLEAR: begin
                     if (req_chan.set_select) valid1_in = '0;
                     else valid0_in = '0;
                     count_in[req_chan.set_select] = '0;
                     state_in = ST_FIN;
                  end
                  CMD_INSERT, CMD_REMOVE, CMD_TEST: begin
                     state_in = ST_ELEM;
                  end
                  CMD_COPY: begin
                     count_in[req_chan.set_select] = count_ff[~req_chan.set_select];
                     state_in = ST_WALK;
                  end
                  CMD_MIN, CMD_MAX, CMD_UNION, CMD_INTERSECT, CMD_DIFF, CMD_EQUAL: begin
                     state_in = ST_WALK;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_ELEM: begin
            wr_addr = WAW'(elem_ff >> BIT_W);
            case (cmd_ff)
               CMD_TEST: found_in = member;
               CMD_INSERT: begin
                  if (range_ff && !member) begin
                     wr_en   = 1'b1;
                     wr_data = dsel | bit_mask;
                     count_in[sel_ff] = count_ff[sel_ff] + COUNT_W'(1);
                  end
               end
               CMD_REMOVE: begin
                  if (member) begin
                     wr_en   = 1'b1;
                     wr_data = dsel & ~bit_mask;
                     count_in[sel_ff] = count_ff[sel_ff] - COUNT_W'(1);
                  end
               end
               default: ;
            endcase
            state_in = ST_FIN;
         end
         ST_WALK: begin
            if (issue_ff != CNT_W'(WORDS)) begin
               rd_en    = 1'b1;
               pend_in  = 1'b1;
               pidx_in  = walk_addr;
               pvld0_in = valid0_ff[walk_addr];
               pvld1_in = valid1_ff[walk_addr];
               issue_in = issue_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_MIN, CMD_MAX: begin
                     if (!hit_ff && dsel != '0) begin
                        hit_in       = 1'b1;
                        edge_word_in = dsel;
                        edge_idx_in  = pidx_ff;
                     end
                  end
                  CMD_UNION: begin
                     wr_en    = 1'b1;
                     wr_data  = d0 | d1;
                     pc_valid = 1'b1;
                  end
                  CMD_INTERSECT: begin
                     wr_en    = 1'b1;
                     wr_data  = d0 & d1;
                     pc_valid = 1'b1;
                  end
                  CMD_DIFF: begin
                     wr_en    = 1'b1;
                     wr_data  = d0 & ~d1;
                     pc_valid = 1'b1;
                  end
                  CMD_COPY: begin
                     wr_en   = 1'b1;
                     wr_data = sel_ff ? d0 : d1;
                  end
                  CMD_EQUAL: begin
                     if (d0 != d1) eq_in = 1'b0;
                  end
                  default: ;
               endcase
            end
            if (walk_done) begin
               case (cmd_ff)
                  CMD_MIN, CMD_MAX: state_in = ST_ENC;
                  CMD_UNION, CMD_INTERSECT, CMD_DIFF: begin
                     count_in[sel_ff] = acc_ff;
                     state_in = ST_FIN;
                  end
                  CMD_EQUAL: begin
                     found_in = eq_ff;
                     state_in = ST_FIN;
                  end
                  default: state_in = ST_FIN;
               endcase
            end
         end
         ST_ENC: begin
            if (hit_ff) begin
               eout_in = ELEM_W'({edge_idx_ff, (cmd_ff == CMD_MAX) ? high_one(edge_word_ff)
                                                                  : low_one(edge_word_ff)});
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_elem_in  = eout_ff;
               rsp_count_in = count_ff[sel_ff];
               rsp_empty_in = (count_ff[sel_ff] == '0);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wr_en) begin
         if (sel_ff) valid1_in[wr_addr] = 1'b1;
         else valid0_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid0_ff    <= '0;
         valid1_ff    <= '0;
         count_ff[0]  <= '0;
         count_ff[1]  <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid0_ff    <= valid0_in;
         valid1_ff    <= valid1_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      sel_ff       <= sel_in;
      elem_ff      <= elem_in;
      range_ff     <= range_in;
      issue_ff     <= issue_in;
      pidx_ff      <= pidx_in;
      pvld0_ff     <= pvld0_in;
      pvld1_ff     <= pvld1_in;
      acc_ff       <= acc_in;
      hit_ff       <= hit_in;
      edge_word_ff <= edge_word_in;
      edge_idx_ff  <= edge_idx_in;
      eq_ff        <= eq_in;
      found_ff     <= found_in;
      eout_ff      <= eout_in;
      rsp_found_ff <= rsp_found_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   bse_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram0 (
      .clock   (clock),
      .wr_en   (wr_en & ~sel_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q0)
   );

   bse_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_ram1 (
      .clock   (clock),
      .wr_en   (wr_en & sel_ff),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (q1)
   );

   bse_popcnt u_popcnt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pc_valid),
      .in_word   (wr_data),
      .out_valid (pc_out_valid),
      .out_count (pc_count),
      .busy      (pc_busy)
   );

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = rsp_found_ff;
   assign rsp_chan.element_out  = rsp_elem_ff;
   assign rsp_chan.member_count = rsp_count_ff;
   assign rsp_chan.is_empty     = rsp_empty_ff;

endmodule

// File: hdl/bse_ram.sv
// Bitmap set engine: generic single-port-write, single-port-read RAM.
// Registered read data. No package dependencies.
module bse_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bse_popcnt.sv
// Bitmap set engine: two-stage population count of one 64-bit word.
// Depends on bse_pkg.
module bse_popcnt import bse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] in_word,
   output logic              out_valid,
   output logic [POP_W-1:0]  out_count,
   output logic              busy
);

   localparam int PARTS = 4;
   localparam int PART_W = WORD_W / PARTS;
   localparam int PCNT_W = 5;

   function automatic logic [PCNT_W-1:0] pop16(input logic [PART_W-1:0] w);
      logic [PCNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < PART_W; i++) begin
         n = n + PCNT_W'(w[i]);
      end
      return n;
   endfunction

   logic              s1_valid_ff, s1_valid_in;
   logic [PCNT_W-1:0] part_ff [PARTS];
   logic [PCNT_W-1:0] part_in [PARTS];
   logic              out_valid_ff, out_valid_in;
   logic [POP_W-1:0]  count_ff, count_in;

   always_comb begin
      s1_valid_in  = in_valid;
      out_valid_in = s1_valid_ff;
      for (int p = 0; p < PARTS; p++) begin
         part_in[p] = pop16(in_word[p*PART_W +: PART_W]);
      end
      count_in = POP_W'(part_ff[0]) + POP_W'(part_ff[1])
               + POP_W'(part_ff[2]) + POP_W'(part_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      part_ff  <= part_in;
      count_ff <= count_in;
   end

   assign out_valid = out_valid_ff;
   assign out_count = count_ff;
   assign busy      = s1_valid_ff | out_valid_ff;

endmodule

// File: verif/testbench.sv
// Self-checking testbench for bitmap_set_engine_core: a directed table, then random commands.
// Each accepted command runs through a behavioral model of the two sets, and results are
// compared in order. Depends on bse_pkg and bse_if from hdl/.
`timescale 1ns / 1ps

module testbench;
   import bse_pkg::*;

   localparam int SET_SIZE      = 256;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 32;
   localparam int NUM_DIRECTED  = 26;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd12;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;
   localparam logic             SET_A = 1'b0;
   localparam logic             SET_B = 1'b1;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic              sel;
      logic [ELEM_W-1:0] element;
   } set_cmd_type;

   typedef struct packed {
      logic               found;
      logic [ELEM_W-1:0]  element_out;
      logic [COUNT_W-1:0] member_count;
      logic               is_empty;
   } set_result_type;

   typedef struct packed {
      set_cmd_type    op;
      logic           typed;
      set_result_type want;
   } directed_row_type;

   localparam set_result_type EMPTY_RESULT = '{1'b0, 8'd0, 9'd0, 1'b1};
   localparam set_result_type NO_RESULT    = '0;

   // Rows with typed = 1 carry their own expected result; the rest use the model.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{CMD_COUNT,     SET_A, 8'd0},   1'b1, EMPTY_RESULT},
      '{'{CMD_MIN,       SET_B, 8'd0},   1'b1, EMPTY_RESULT},
      '{'{CMD_MAX,       SET_A, 8'd0},   1'b1, EMPTY_RESULT},
      '{'{CMD_EQUAL,     SET_A, 8'd0},   1'b1, '{1'b1, 8'd0, 9'd0, 1'b1}},
      '{'{CMD_INSERT,    SET_A, 8'd0},   1'b1, '{1'b0, 8'd0, 9'd1, 1'b0}},
      '{'{CMD_INSERT,    SET_A, 8'd255}, 1'b1, '{1'b0, 8'd0, 9'd2, 1'b0}},
      '{'{CMD_INSERT,    SET_A, 8'd255}, 1'b1, '{1'b0, 8'd0, 9'd2, 1'b0}},
      '{'{CMD_MIN,       SET_A, 8'd0},   1'b1, '{1'b0, 8'd0, 9'd2, 1'b0}},
      '{'{CMD_MAX,       SET_A, 8'd0},   1'b1, '{1'b0, 8'd255, 9'd2, 1'b0}},
      '{'{CMD_TEST,      SET_A, 8'd255}, 1'b1, '{1'b1, 8'd0, 9'd2, 1'b0}},
      '{'{CMD_TEST,      SET_A, 8'd128}, 1'b1, '{1'b0, 8'd0, 9'd2, 1'b0}},
      '{'{CMD_TEST,      SET_B, 8'd0},   1'b1, EMPTY_RESULT},
      '{'{CMD_INSERT,    SET_B, 8'd128}, 1'b0, NO_RESULT},
      '{'{CMD_INSERT,    SET_B, 8'd255}, 1'b0, NO_RESULT},
      '{'{CMD_EQUAL,     SET_B, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_UNION,     SET_B, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_INTERSECT, SET_A, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_DIFF,      SET_B, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_COPY,      SET_A, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_COUNT,     SET_B, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_REMOVE,    SET_A, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_REMOVE,    SET_A, 8'd0},   1'b0, NO_RESULT},
      '{'{CMD_UNUSED_FIRST, SET_B, 8'd170}, 1'b0, NO_RESULT},
      '{'{CMD_UNUSED_LAST,  SET_A, 8'd85},  1'b0, NO_RESULT},
      '{'{CMD_CLEAR,     SET_A, 8'd0},   1'b1, EMPTY_RESULT},
      '{'{CMD_CLEAR,     SET_B, 8'd0},   1'b1, EMPTY_RESULT}
   };

   logic clock = 1'b0;
   logic reset;

   bse_req_if req_bus ();
   bse_rsp_if rsp_bus ();

   bitmap_set_engine_core #(
      .SET_SIZE (SET_SIZE)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state: membership bits and kept count per set.
   logic [SET_SIZE-1:0] member_bits  [2];
   logic [COUNT_W-1:0]  member_tally [2];

   set_result_type pending_results [$];
   int          mismatch_count = 0;
   int          result_index   = 0;
   bit          steady_run     = 1'b0;
   bit          hold_request   = 1'b0;

   function automatic set_result_type next_set_result(input set_cmd_type c);
      set_result_type r;
      logic        s;
      logic        o;
      r = '0;
      s = c.sel;
      o = ~c.sel;
      case (c.cmd)
         CMD_CLEAR: begin
            member_bits[s]  = '0;
            member_tally[s] = '0;
         end
         CMD_INSERT: begin
            if (int'(c.element) < SET_SIZE && !member_bits[s][c.element]) begin
               member_bits[s][c.element] = 1'b1;
               member_tally[s]++;
            end
         end
         CMD_REMOVE: begin
            if (int'(c.element) < SET_SIZE && member_bits[s][c.element]) begin
               member_bits[s][c.element] = 1'b0;
               member_tally[s]--;
            end
         end
         CMD_TEST: r.found = (int'(c.element) < SET_SIZE) && member_bits[s][c.element];
         CMD_MIN: begin
            for (int pos = SET_SIZE - 1; pos >= 0; pos--)
               if (member_bits[s][pos]) r.element_out = ELEM_W'(pos);
         end
         CMD_MAX: begin
            for (int pos = 0; pos < SET_SIZE; pos++)
               if (member_bits[s][pos]) r.element_out = ELEM_W'(pos);
         end
         CMD_UNION, CMD_INTERSECT, CMD_DIFF: begin
            if (c.cmd == CMD_UNION)
               member_bits[s] = member_bits[0] | member_bits[1];
            else if (c.cmd == CMD_INTERSECT)
               member_bits[s] = member_bits[0] & member_bits[1];
            else
               member_bits[s] = member_bits[0] & ~member_bits[1];
            member_tally[s] = COUNT_W'($countones(member_bits[s]));
         end
         CMD_COPY: begin
            member_bits[s]  = member_bits[o];
            member_tally[s] = member_tally[o];
         end
         CMD_EQUAL: r.found = (member_bits[0] == member_bits[1]);
         default: ;
      endcase
      r.member_count = member_tally[s];
      r.is_empty     = (member_tally[s] == '0);
      return r;
   endfunction

   function automatic set_cmd_type random_command();
      set_cmd_type c;
      int unsigned roll;
      int unsigned pick;
      roll  = $urandom_range(0, 99);
      pick  = $urandom_range(0, 99);
      c.sel = 1'($urandom_range(0, 1));
      // Bias elements toward a small window so removes and tests hit members.
      if (pick < 40)
         c.element = ELEM_W'($urandom_range(0, 15));
      else if (pick < 55)
         c.element = (pick < 48) ? '0 : '1;
      else
         c.element = ELEM_W'($urandom());
      if (roll < 34)      c.cmd = CMD_INSERT;
      else if (roll < 50) c.cmd = CMD_REMOVE;
      else if (roll < 64) c.cmd = CMD_TEST;
      else if (roll < 69) c.cmd = CMD_MIN;
      else if (roll < 74) c.cmd = CMD_MAX;
      else if (roll < 78) c.cmd = CMD_UNION;
      else if (roll < 81) c.cmd = CMD_INTERSECT;
      else if (roll < 84) c.cmd = CMD_DIFF;
      else if (roll < 87) c.cmd = CMD_COPY;
      else if (roll < 91) c.cmd = CMD_EQUAL;
      else if (roll < 94) c.cmd = CMD_COUNT;
      else if (roll < 96) c.cmd = CMD_CLEAR;
      else c.cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      return c;
   endfunction

   function automatic void note_mismatch(input string field, input logic [15:0] want,
                                         input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at result %0d: %s expected %0d got %0d",
                  result_index, field, want, got);
   endfunction

   // Drives one command and records its expected result at the transfer.
   task automatic send_command(input set_cmd_type c, input logic typed,
                               input set_result_type want);
      set_result_type predicted;
      @(negedge clock);
      while (!steady_run && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= c.cmd;
      req_bus.set_select <= c.sel;
      req_bus.element    <= c.element;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = next_set_result(c);
      pending_results.push_back(typed ? want : predicted);
   endtask

   initial begin : stimulus
      logic burst_sel;
      member_bits[0]  = '0;
      member_bits[1]  = '0;
      member_tally[0] = '0;
      member_tally[1] = '0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= '0;
      req_bus.set_select <= 1'b0;
      req_bus.element    <= '0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_command(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_run = (n >= 200 && n < 500);
         if (n == 1000)
            hold_request = 1'b1;
         // Fill a whole set now and then to reach a full count.
         if (n == 600 || n == 1300) begin
            burst_sel = 1'($urandom_range(0, 1));
            for (int e = 0; e < SET_SIZE; e++)
               send_command(set_cmd_type'{CMD_INSERT, burst_sel, ELEM_W'(e)}, 1'b0,
                            NO_RESULT);
         end
         send_command(random_command(), 1'b0, NO_RESULT);
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : result_sink
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_bus.ready <= steady_run || ($urandom_range(0, 99) >= 6);
      end
   end

   always @(posedge clock) begin
      set_result_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected transfer, member_count", '0,
                          16'(rsp_bus.member_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.found !== want.found)
               note_mismatch("found", 16'(want.found), 16'(rsp_bus.found));
            if (rsp_bus.element_out !== want.element_out)
               note_mismatch("element_out", 16'(want.element_out),
                             16'(rsp_bus.element_out));
            if (rsp_bus.member_count !== want.member_count)
               note_mismatch("member_count", 16'(want.member_count),
                             16'(rsp_bus.member_count));
            if (rsp_bus.is_empty !== want.is_empty)
               note_mismatch("is_empty", 16'(want.is_empty), 16'(rsp_bus.is_empty));
         end
         result_index++;
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
hdl/bse_pkg.sv
hdl/bse_if.sv
hdl/bse_ram.sv
hdl/bse_popcnt.sv
hdl/bitmap_set_engine_core.sv
verif/testbench.sv
